// ----- rtl/tcw_pkg.sv -----
// shared types and constants for the text console writer
package tcw_pkg;

   // screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;

   // field widths
   localparam int POS_W  = 11;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int CELL_W = CHAR_W + ATTR_W;
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS + 1);

   // control codes
   localparam logic [CHAR_W-1:0] CODE_CR = 8'd13;
   localparam logic [CHAR_W-1:0] CODE_LF = 8'd10;
   localparam logic [CHAR_W-1:0] CODE_BS = 8'd8;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // register file
   localparam int                CSR_DATA_W      = 32;
   localparam int                CSR_ADDR_W      = 2;
   localparam logic [ATTR_W-1:0] ATTR_RESET      = 8'h07;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic              op;
      logic [CHAR_W-1:0] char_code;
      logic [POS_W-1:0]  cell_index;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0]  cursor_pos;
      logic [CHAR_W-1:0] cell_char;
      logic [ATTR_W-1:0] cell_attr;
      logic              scrolled;
   } rsp_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_PUT,
      CMD_NEWLINE,
      CMD_BACKSPACE,
      CMD_READ,
      CMD_READ_OUT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [CHAR_W-1:0] char_code;
      logic [POS_W-1:0]  cell_index;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ----- rtl/tcw_ram.sv -----
// generic single write port, single read port ram with registered read
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/tcw_front.sv -----
// request intake: handshake and classification into back-end commands
module tcw_front (
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tcw_pkg::req_type      req_payload,
   input  tcw_pkg::q_status_type q_status,
   input  logic                  clearing,
   output logic                  push,
   output tcw_pkg::cmd_type      push_cmd
);
   import tcw_pkg::*;

   assign req_stall = q_status.full | clearing;
   assign push      = req_valid & ~req_stall;

   always_comb begin
      push_cmd.char_code  = req_payload.char_code;
      push_cmd.cell_index = req_payload.cell_index;
      if (req_payload.op == OP_READ) begin
         if (req_payload.cell_index < POS_W'(CELL_COUNT)) begin
            push_cmd.kind = CMD_READ;
         end else begin
            push_cmd.kind = CMD_READ_OUT;
         end
      end else begin
         unique case (req_payload.char_code)
            CODE_CR: push_cmd.kind = CMD_NONE;
            CODE_LF: push_cmd.kind = CMD_NEWLINE;
            CODE_BS: push_cmd.kind = CMD_BACKSPACE;
            default: push_cmd.kind = CMD_PUT;
         endcase
      end
   end

endmodule

// ----- rtl/tcw_cmd_queue.sv -----
// short command queue between front and back
module tcw_cmd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  tcw_pkg::cmd_type      push_cmd,
   input  logic                  pop,
   output tcw_pkg::cmd_type      head_cmd,
   output tcw_pkg::q_status_type q_status
);
   import tcw_pkg::*;

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] ptr);
      if (ptr == QPTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + QPTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            entry_ff[wr_ptr_ff] <= push_cmd;
            wr_ptr_ff           <= ptr_next(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= ptr_next(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

   assign head_cmd       = entry_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !push)
      else $error("push into full command queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_status.empty |-> !pop)
      else $error("pop from empty command queue");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + QCNT_W'(1)))
      else $error("queue count did not follow a push");

endmodule

// ----- rtl/tcw_back.sv -----
// command execution: screen store, cursor, scroll copy and response register
module tcw_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [tcw_pkg::ATTR_W-1:0]  text_attribute,
   input  tcw_pkg::cmd_type            head_cmd,
   input  tcw_pkg::q_status_type       q_status,
   output logic                        pop,
   output logic                        clearing,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output tcw_pkg::rsp_type            rsp_payload
);
   import tcw_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_SCROLL,
      S_BLANK,
      S_RESP
   } state_type;

   localparam logic [POS_W-1:0] LAST_CELL = POS_W'(CELL_COUNT - 1);
   localparam logic [POS_W-1:0] LAST_COPY = POS_W'(CELL_COUNT - COLUMNS - 1);
   localparam logic [COL_W-1:0] COL_LAST  = COL_W'(COLUMNS - 1);

   state_type         state_ff;
   logic [POS_W-1:0]  scan_ff;
   logic              wr_pend_ff;
   logic [POS_W-1:0]  wr_addr_ff;
   cmd_type           cmd_ff;
   logic [COL_W-1:0]  col_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [CHAR_W-1:0] res_char_ff;
   logic [ATTR_W-1:0] res_attr_ff;
   logic              res_scr_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_payload_ff;

   logic [COL_W-1:0]  col_in;
   logic [ROW_W-1:0]  row_in;
   logic [POS_W-1:0]  pos_in;
   logic              scroll_need;
   logic              ex_wr;
   logic [POS_W-1:0]  ex_addr;
   logic [CELL_W-1:0] ex_data;
   logic [CELL_W-1:0] blank;

   logic              ram_wr_en;
   logic [POS_W-1:0]  ram_wr_addr;
   logic [CELL_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [POS_W-1:0]  ram_rd_addr;
   logic [CELL_W-1:0] ram_rd_data;
   logic              out_free;

   assign blank    = {text_attribute, CHAR_W'(0)};
   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign pop      = (state_ff == S_IDLE) & ~q_status.empty;
   assign clearing = (state_ff == S_CLEAR);

   // cursor step for the command in flight
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      pos_in  = pos_ff;
      ex_wr   = 1'b0;
      ex_addr = pos_ff;
      ex_data = blank;
      case (cmd_ff.kind)
         CMD_PUT: begin
            ex_wr   = 1'b1;
            ex_data = {text_attribute, cmd_ff.char_code};
            pos_in  = pos_ff + POS_W'(1);
            if (col_ff == COL_LAST) begin
               col_in = '0;
               row_in = row_ff + ROW_W'(1);
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
         CMD_NEWLINE: begin
            ex_wr  = 1'b1;
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
            pos_in = pos_ff - POS_W'(col_ff) + POS_W'(COLUMNS);
         end
         CMD_BACKSPACE: begin
            if (pos_ff != '0) begin
               ex_wr   = 1'b1;
               ex_addr = pos_ff - POS_W'(1);
               pos_in  = pos_ff - POS_W'(1);
               if (col_ff == '0) begin
                  col_in = COL_LAST;
                  row_in = row_ff - ROW_W'(1);
               end else begin
                  col_in = col_ff - COL_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
      scroll_need = (row_in == ROW_W'(ROWS));
   end

   // store port steering
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = scan_ff;
      ram_wr_data = blank;
      ram_rd_en   = 1'b0;
      ram_rd_addr = scan_ff + POS_W'(COLUMNS);
      unique case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = '0;
         end
         S_IDLE: begin
            ram_rd_en   = pop & (head_cmd.kind == CMD_READ);
            ram_rd_addr = head_cmd.cell_index;
         end
         S_EXEC: begin
            ram_wr_en   = ex_wr;
            ram_wr_addr = ex_addr;
            ram_wr_data = ex_data;
         end
         S_SCROLL: begin
            ram_rd_en   = 1'b1;
            ram_wr_en   = wr_pend_ff;
            ram_wr_addr = wr_addr_ff;
            ram_wr_data = ram_rd_data;
         end
         S_BLANK: begin
            ram_wr_en = 1'b1;
            if (wr_pend_ff) begin
               ram_wr_addr = wr_addr_ff;
               ram_wr_data = ram_rd_data;
            end
         end
         S_RESP: begin
         end
         default: begin
         end
      endcase
   end

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         scan_ff      <= '0;
         wr_pend_ff   <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new response replaces one leaving in the same cycle
         if (state_ff == S_RESP && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               if (scan_ff == LAST_CELL) begin
                  scan_ff  <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  scan_ff <= scan_ff + POS_W'(1);
               end
            end
            S_IDLE: begin
               if (pop) begin
                  cmd_ff   <= head_cmd;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               res_scr_ff <= scroll_need;
               if (cmd_ff.kind == CMD_READ) begin
                  res_char_ff <= ram_rd_data[CHAR_W-1:0];
                  res_attr_ff <= ram_rd_data[CELL_W-1:CHAR_W];
               end else begin
                  res_char_ff <= '0;
                  res_attr_ff <= '0;
               end
               col_ff <= col_in;
               if (scroll_need) begin
                  row_ff     <= ROW_W'(ROWS - 1);
                  pos_ff     <= pos_in - POS_W'(COLUMNS);
                  scan_ff    <= '0;
                  wr_pend_ff <= 1'b0;
                  state_ff   <= S_SCROLL;
               end else begin
                  row_ff   <= row_in;
                  pos_ff   <= pos_in;
                  state_ff <= S_RESP;
               end
            end
            S_SCROLL: begin
               wr_pend_ff <= 1'b1;
               wr_addr_ff <= scan_ff;
               scan_ff    <= scan_ff + POS_W'(1);
               if (scan_ff == LAST_COPY) begin
                  state_ff <= S_BLANK;
               end
            end
            S_BLANK: begin
               if (wr_pend_ff) begin
                  wr_pend_ff <= 1'b0;
               end else if (scan_ff == LAST_CELL) begin
                  scan_ff  <= '0;
                  state_ff <= S_RESP;
               end else begin
                  scan_ff <= scan_ff + POS_W'(1);
               end
            end
            S_RESP: begin
               if (out_free) begin
                  rsp_payload_ff.cursor_pos <= pos_ff;
                  rsp_payload_ff.cell_char  <= res_char_ff;
                  rsp_payload_ff.cell_attr  <= res_attr_ff;
                  rsp_payload_ff.scrolled   <= res_scr_ff;
                  state_ff                  <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !ram_wr_en)
      else $error("store written while idle");

   a_pos_matches: assert property (@(posedge clock) disable iff (reset)
      pos_ff == POS_W'(POS_W'(row_ff) * POS_W'(COLUMNS) + POS_W'(col_ff)))
      else $error("linear cursor out of step with row and column");

   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      row_ff <= ROW_W'(ROWS - 1))
      else $error("cursor row beyond last row");

   a_resp_issue: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("response not issued with free output register");

endmodule

// ----- rtl/text_console_writer_core.sv -----
// top level of the text console writer: csr, front, command queue and back
//
//  channel   ports                          direction  flow
//  request   req_valid/req_stall/req_payload  in       valid, stall from block
//  response  rsp_valid/rsp_stall/rsp_payload  out      valid, stall from sink
//  csr       psel/penable/pwrite/paddr/...    in/out   apb style, pready tied high
//
//  an ordinary request passes through the back end as pop, execute and respond
//  a scrolling write adds a copy of every row up by one and a blank of the last row,
//  both done through the single write port of the screen store
//  after reset a clearing pass zeroes every cell of the store; requests stall meanwhile
//  the two-entry command queue accepts until full while a response waits on rsp_stall
module text_console_writer_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  tcw_pkg::req_type                   req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output tcw_pkg::rsp_type                   rsp_payload,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [tcw_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [tcw_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);
   import tcw_pkg::*;

   // attribute register, the only csr; byte offset bits select nothing else
   logic [ATTR_W-1:0] attr_ff;
   logic              csr_write;

   // front to queue
   logic         push;
   cmd_type      push_cmd;
   // queue to back
   cmd_type      head_cmd;
   q_status_type q_status;
   logic         pop;
   // back busy zeroing the store
   logic         clearing;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= ATTR_RESET;
      end else if (csr_write) begin
         attr_ff <= pwdata[ATTR_W-1:0];
      end
   end

   // reads at any offset within the word return the attribute
   assign prdata = (paddr == '0) ? {(CSR_DATA_W - ATTR_W)'(0), attr_ff}
                                 : {(CSR_DATA_W - ATTR_W)'(0), attr_ff};

   // intake and classification
   tcw_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_status    (q_status),
      .clearing    (clearing),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   // decouples intake from execution
   tcw_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_status (q_status)
   );

   // execution against the screen store, owns the response register
   tcw_back u_back (
      .clock          (clock),
      .reset          (reset),
      .text_attribute (attr_ff),
      .head_cmd       (head_cmd),
      .q_status       (q_status),
      .pop            (pop),
      .clearing       (clearing),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload)
   );

endmodule
